@@ design/hrfs_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// hrfs_pkg: shared types and constants of the request field splitter
// Byte classes, parser phases, field kinds and the word passed from the
// front to the back through the queue.
// ----------------------------------------------------------------------------
package hrfs_pkg;

  localparam int FIELD_BYTES_DEFAULT = 256;
  localparam int QUEUE_DEPTH_DEFAULT = 2;

  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_SLASH = 8'h2F;
  localparam logic [7:0] CHAR_DOT   = 8'h2E;
  localparam logic [7:0] CHAR_COLON = 8'h3A;

  typedef enum logic [3:0] {
    CL_LETTER,
    CL_DIGIT,
    CL_BLANK,
    CL_CR,
    CL_LF,
    CL_SLASH,
    CL_DOT,
    CL_COLON,
    CL_OTHER
  } byte_class_t;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_METHOD,
    PH_PATH,
    PH_VERSION,
    PH_HEADERS,
    PH_BODY
  } phase_t;

  typedef enum logic [2:0] {
    KIND_METHOD,
    KIND_PATH,
    KIND_VERSION,
    KIND_HEADERS,
    KIND_BODY
  } field_kind_t;

  typedef struct packed {
    logic        sp_valid;
    logic [7:0]  sp_pos;
    logic        sp_ovf;
    logic        b_valid;
    field_kind_t b_kind;
    logic [7:0]  b_byte;
    logic [7:0]  b_pos;
    logic        b_ovf;
  } job_t;

  function automatic byte_class_t classify(input logic [7:0] b);
    byte_class_t c;
    if ((b >= 8'd65 && b <= 8'd90) || (b >= 8'd97 && b <= 8'd122)) c = CL_LETTER;
    else if (b >= 8'd48 && b <= 8'd57) c = CL_DIGIT;
    else if (b == CHAR_CR) c = CL_CR;
    else if (b == CHAR_LF) c = CL_LF;
    else if (b == CHAR_SPACE || b == CHAR_TAB) c = CL_BLANK;
    else if (b == CHAR_SLASH) c = CL_SLASH;
    else if (b == CHAR_DOT) c = CL_DOT;
    else if (b == CHAR_COLON) c = CL_COLON;
    else c = CL_OTHER;
    return c;
  endfunction

endpackage
`default_nettype wire

@@ design/hrfs_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// hrfs_front: byte classifier and phase machine
// Classifies each accepted byte, advances the parser phase and the held
// CR / pending-space flags, and builds one queue word per byte with results.
// ----------------------------------------------------------------------------
module hrfs_front #(
  parameter int FIELD_BYTES = hrfs_pkg::FIELD_BYTES_DEFAULT
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [7:0]    byte_value,
  input  wire logic          last_byte,
  output logic               push_valid,
  input  wire logic          push_ready,
  output hrfs_pkg::job_t     push_data
);

  localparam int WPW = $clog2(FIELD_BYTES + 1);
  localparam int XW  = (WPW > 8) ? WPW : 9;
  localparam logic [WPW-1:0] FULL_POS = WPW'(FIELD_BYTES);
  localparam logic [WPW-1:0] LAST_POS = WPW'(FIELD_BYTES - 1);

  hrfs_pkg::phase_t ph, ph_next;
  logic [WPW-1:0]   wp, wp_next;
  logic             cr_held, cr_held_next;
  logic             space_pending, space_pending_next;
  logic             second_cr_held, second_cr_held_next;

  hrfs_pkg::byte_class_t cls;
  hrfs_pkg::job_t        job;
  logic                  done;
  logic                  emit_b;
  logic                  accept;

  function automatic logic [7:0] sat_pos(input logic [WPW-1:0] w);
    logic [WPW-1:0] p;
    logic [XW-1:0]  px;
    p  = (w >= FULL_POS) ? LAST_POS : w;
    px = XW'(p);
    return (px > XW'(255)) ? 8'hFF : px[7:0];
  endfunction

  assign cls        = hrfs_pkg::classify(byte_value);
  assign in_ready   = push_ready;
  assign accept     = in_valid && in_ready;
  assign push_valid = in_valid && (job.sp_valid || job.b_valid);
  assign push_data  = job;

  always_comb begin
    ph_next             = ph;
    wp_next             = wp;
    cr_held_next        = cr_held;
    space_pending_next  = space_pending;
    second_cr_held_next = second_cr_held;
    job                 = '0;
    done                = 1'b0;
    emit_b              = 1'b0;

    if (ph == hrfs_pkg::PH_HEADERS && space_pending) begin
      if (second_cr_held) begin
        space_pending_next  = 1'b0;
        second_cr_held_next = 1'b0;
        if (cls == hrfs_pkg::CL_LF) begin
          ph_next = hrfs_pkg::PH_BODY;
          wp_next = '0;
          done    = 1'b1;
        end else begin
          job.sp_valid = 1'b1;
        end
      end else if (cls == hrfs_pkg::CL_CR) begin
        second_cr_held_next = 1'b1;
        done                = 1'b1;
      end else begin
        space_pending_next = 1'b0;
        job.sp_valid       = 1'b1;
      end
    end else if (cr_held) begin
      cr_held_next = 1'b0;
      if (cls == hrfs_pkg::CL_LF) begin
        if (ph == hrfs_pkg::PH_VERSION) begin
          ph_next = hrfs_pkg::PH_HEADERS;
          wp_next = '0;
        end else if (ph == hrfs_pkg::PH_HEADERS) begin
          space_pending_next = 1'b1;
        end
        done = 1'b1;
      end
    end

    if (job.sp_valid) begin
      job.sp_pos = sat_pos(wp_next);
      job.sp_ovf = (wp_next >= FULL_POS);
      if (wp_next < FULL_POS) wp_next = wp_next + 1'b1;
    end

    if (!done) begin
      unique case (ph_next)
        hrfs_pkg::PH_IDLE: begin
          if (cls == hrfs_pkg::CL_LETTER) begin
            ph_next = hrfs_pkg::PH_METHOD;
            wp_next = '0;
            emit_b  = 1'b1;
          end
        end
        hrfs_pkg::PH_METHOD: begin
          if (cls == hrfs_pkg::CL_LETTER) emit_b = 1'b1;
          else if (cls == hrfs_pkg::CL_BLANK) begin
            ph_next = hrfs_pkg::PH_PATH;
            wp_next = '0;
          end
        end
        hrfs_pkg::PH_PATH: begin
          if (cls == hrfs_pkg::CL_LETTER || cls == hrfs_pkg::CL_SLASH) emit_b = 1'b1;
          else if (cls == hrfs_pkg::CL_BLANK) begin
            ph_next = hrfs_pkg::PH_VERSION;
            wp_next = '0;
          end
        end
        hrfs_pkg::PH_VERSION: begin
          if (cls == hrfs_pkg::CL_LETTER || cls == hrfs_pkg::CL_SLASH ||
              cls == hrfs_pkg::CL_DIGIT || cls == hrfs_pkg::CL_DOT) emit_b = 1'b1;
          else if (cls == hrfs_pkg::CL_CR) cr_held_next = 1'b1;
        end
        hrfs_pkg::PH_HEADERS: begin
          if (cls == hrfs_pkg::CL_CR) cr_held_next = 1'b1;
          else if (cls != hrfs_pkg::CL_LF) emit_b = 1'b1;
        end
        hrfs_pkg::PH_BODY: begin
          if (cls == hrfs_pkg::CL_LETTER) emit_b = 1'b1;
        end
        default: ;
      endcase
    end

    if (emit_b) begin
      job.b_valid = 1'b1;
      job.b_kind  = hrfs_pkg::field_kind_t'(3'(ph_next - 3'd1));
      job.b_byte  = byte_value;
      job.b_pos   = sat_pos(wp_next);
      job.b_ovf   = (wp_next >= FULL_POS);
      if (wp_next < FULL_POS) wp_next = wp_next + 1'b1;
    end

    if (last_byte) begin
      ph_next             = hrfs_pkg::PH_IDLE;
      wp_next             = '0;
      cr_held_next        = 1'b0;
      space_pending_next  = 1'b0;
      second_cr_held_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ph             <= hrfs_pkg::PH_IDLE;
      wp             <= '0;
      cr_held        <= 1'b0;
      space_pending  <= 1'b0;
      second_cr_held <= 1'b0;
    end else if (accept) begin
      ph             <= ph_next;
      wp             <= wp_next;
      cr_held        <= cr_held_next;
      space_pending  <= space_pending_next;
      second_cr_held <= second_cr_held_next;
    end
  end

`ifndef SYNTHESIS
  a_pending_in_headers: assert property (@(posedge clk) disable iff (rst)
    space_pending |-> ph == hrfs_pkg::PH_HEADERS)
    else $error("pending space outside headers");
  a_second_cr_needs_space: assert property (@(posedge clk) disable iff (rst)
    second_cr_held |-> space_pending && !cr_held)
    else $error("second CR held without pending space");
  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    accept && last_byte |=> ph == hrfs_pkg::PH_IDLE && wp == '0 && !cr_held && !space_pending)
    else $error("last byte did not return to idle");
`endif

endmodule
`default_nettype wire

@@ design/hrfs_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// hrfs_queue: short word queue between front and back
// First-in first-out buffer of result words; lets either side stall alone.
// ----------------------------------------------------------------------------
module hrfs_queue #(
  parameter int DEPTH = hrfs_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push_valid,
  output logic                 push_ready,
  input  wire hrfs_pkg::job_t  push_data,
  output logic                 pop_valid,
  input  wire logic            pop_ready,
  output hrfs_pkg::job_t       pop_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  hrfs_pkg::job_t slots [DEPTH];
  logic [PW-1:0]  wr_ptr, rd_ptr;
  logic [CW-1:0]  count;
  logic           do_push, do_pop;

  assign push_ready = (count != CW'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (do_push && !do_pop) count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("queue count out of range");
  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    (count == '0 || count == CW'(DEPTH)) |-> wr_ptr == rd_ptr)
    else $error("queue pointers out of step with count");
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    do_push && !do_pop |=> count == $past(count) + 1'b1)
    else $error("queue count missed a push");
`endif

endmodule
`default_nettype wire

@@ design/hrfs_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// hrfs_back: result sequencer
// Takes one queue word at a time into the output register and presents
// the folded space first, then the byte result.
// ----------------------------------------------------------------------------
module hrfs_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            q_valid,
  output logic                 q_ready,
  input  wire hrfs_pkg::job_t  q_data,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output logic [2:0]           field_kind,
  output logic [7:0]           out_byte,
  output logic [7:0]           field_position,
  output logic                 overflow,
  output logic                 run_last
);

  hrfs_pkg::job_t cur;
  logic           have;
  logic           sub;
  logic           show_sp;
  logic           fire, finish, load;

  assign show_sp        = cur.sp_valid && !sub;
  assign out_valid      = have;
  assign field_kind     = show_sp ? hrfs_pkg::KIND_HEADERS : cur.b_kind;
  assign out_byte       = show_sp ? hrfs_pkg::CHAR_SPACE : cur.b_byte;
  assign field_position = show_sp ? cur.sp_pos : cur.b_pos;
  assign overflow       = show_sp ? cur.sp_ovf : cur.b_ovf;
  assign run_last       = show_sp ? !cur.b_valid : 1'b1;

  assign fire    = have && out_ready;
  assign finish  = fire && run_last;
  assign load    = !have || finish;
  assign q_ready = load;

  always_ff @(posedge clk) begin
    if (load && q_valid) cur <= q_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      have <= 1'b0;
      sub  <= 1'b0;
    end else if (load) begin
      have <= q_valid;
      sub  <= 1'b0;
    end else if (fire) begin
      sub  <= 1'b1;
    end
  end

`ifndef SYNTHESIS
  a_sub_shape: assert property (@(posedge clk) disable iff (rst)
    sub |-> have && cur.sp_valid && cur.b_valid)
    else $error("second half shown without a two-result word");
  a_byte_follows_space: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !run_last |=> out_valid && sub)
    else $error("byte result lost after folded space");
  a_space_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && show_sp |-> field_kind == hrfs_pkg::KIND_HEADERS &&
                             out_byte == hrfs_pkg::CHAR_SPACE)
    else $error("folded space outside headers");
  a_word_nonempty: assert property (@(posedge clk) disable iff (rst)
    have |-> cur.sp_valid || cur.b_valid)
    else $error("empty word in output register");
`endif

endmodule
`default_nettype wire

@@ design/http_request_field_splitter.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// http_request_field_splitter: HTTP request line and header field splitter
// Routes request bytes to method, path, version, header and body fields.
// ----------------------------------------------------------------------------
// One byte is accepted per cycle while the queue has room. Each accepted
// byte yields zero, one or two results; two results come when a byte
// releases a folded header space, and the output register then presents
// both in turn. The phase machine in the front settles each byte in its
// accept cycle, and the queue of QUEUE_DEPTH words absorbs two-result bytes
// and output stalls. in_ready follows the free space of the queue, so a full
// queue holds off every byte, including bytes that yield no result; with the
// output always ready, second results slow the input once the queue has
// filled. The first result of a byte passes the queue, then the output register.
// ----------------------------------------------------------------------------
module http_request_field_splitter #(
  parameter int FIELD_BYTES = hrfs_pkg::FIELD_BYTES_DEFAULT,
  parameter int QUEUE_DEPTH = hrfs_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  byte_value,
  input  wire logic        last_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       field_kind,
  output logic [7:0]       out_byte,
  output logic [7:0]       field_position,
  output logic             overflow,
  output logic             run_last
);

  logic           push_valid, push_ready;
  hrfs_pkg::job_t push_data;
  logic           q_valid, q_ready;
  hrfs_pkg::job_t q_data;

  hrfs_front #(.FIELD_BYTES(FIELD_BYTES)) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .byte_value (byte_value),
    .last_byte  (last_byte),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  hrfs_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_data)
  );

  hrfs_back u_back (
    .clk            (clk),
    .rst            (rst),
    .q_valid        (q_valid),
    .q_ready        (q_ready),
    .q_data         (q_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .field_kind     (field_kind),
    .out_byte       (out_byte),
    .field_position (field_position),
    .overflow       (overflow),
    .run_last       (run_last)
  );

endmodule
`default_nettype wire

@@ verif/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for http_request_field_splitter
// Pushes HTTP-like request bytes through the valid/ready input. A software
// copy of the phase machine predicts every field word. Each word that leaves
// the block is compared with the oldest prediction. The sender and receiver
// throttle at random, and long stalls and drains are added on top.
// ----------------------------------------------------------------------------
module tb;
  import hrfs_pkg::*;

  localparam int FIELD_CAP = 256;
  localparam int LONG_HOLD = 400;

  typedef struct {
    logic [7:0] data;
    logic       last;
    int         tx_idle;
    int         rx_idle;
    bit         drain;
    bit         stall;
  } req_item_t;

  typedef struct {
    logic [2:0] kind;
    logic [7:0] data;
    logic [7:0] pos;
    logic       ovf;
    logic       last;
  } field_word_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] byte_value = 8'd0;
  logic       last_byte = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [2:0] field_kind;
  logic [7:0] out_byte;
  logic [7:0] field_position;
  logic       overflow;
  logic       run_last;

  req_item_t   request_words[$];
  field_word_t field_words_due[$];
  field_word_t step_words[$];
  logic [7:0]  req_bytes[$];

  int failures = 0;
  int queued_count = 0;
  int cur_tx_idle = 0;
  int cur_rx_idle = 0;
  bit next_drain = 1'b0;
  bit next_stall = 1'b0;
  int rx_idle_pct = 0;
  int stall_requests = 0;
  int stall_served = 0;
  int stall_left = 0;

  phase_t      parse_phase = PH_IDLE;
  int unsigned field_fill = 0;
  bit          cr_seen = 1'b0;
  bit          fold_pending = 1'b0;
  bit          fold_cr_seen = 1'b0;

  http_request_field_splitter #(.FIELD_BYTES(FIELD_CAP)) DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .byte_value(byte_value),
    .last_byte(last_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .field_kind(field_kind),
    .out_byte(out_byte),
    .field_position(field_position),
    .overflow(overflow),
    .run_last(run_last)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------- predictor
  function automatic byte_class_t sort_byte(input logic [7:0] b);
    if ((b >= "A" && b <= "Z") || (b >= "a" && b <= "z")) return CL_LETTER;
    if (b >= "0" && b <= "9") return CL_DIGIT;
    if (b == CHAR_CR) return CL_CR;
    if (b == CHAR_LF) return CL_LF;
    if (b == CHAR_SPACE || b == CHAR_TAB) return CL_BLANK;
    if (b == CHAR_SLASH) return CL_SLASH;
    if (b == CHAR_DOT) return CL_DOT;
    if (b == CHAR_COLON) return CL_COLON;
    return CL_OTHER;
  endfunction

  task automatic reset_parser();
    parse_phase = PH_IDLE;
    field_fill = 0;
    cr_seen = 1'b0;
    fold_pending = 1'b0;
    fold_cr_seen = 1'b0;
  endtask

  task automatic enter_phase(input phase_t p);
    parse_phase = p;
    field_fill = 0;
  endtask

  task automatic emit_word(input logic [7:0] b);
    field_word_t w;
    if (step_words.size() >= 2) return;
    w.ovf = 1'b0;
    if (field_fill >= FIELD_CAP) begin
      w.pos = (FIELD_CAP - 1 > 255) ? 8'd255 : 8'(FIELD_CAP - 1);
      w.ovf = 1'b1;
    end else begin
      w.pos = (field_fill > 255) ? 8'd255 : 8'(field_fill);
      field_fill++;
    end
    w.kind = 3'(int'(parse_phase) - 1);
    w.data = b;
    w.last = 1'b0;
    step_words.push_back(w);
  endtask

  task automatic predict_fields(input logic [7:0] b, input logic last);
    byte_class_t c;
    bit          done;
    field_word_t w;
    c = sort_byte(b);
    done = 1'b0;
    step_words.delete();
    if (parse_phase == PH_HEADERS && fold_pending) begin
      if (fold_cr_seen) begin
        fold_pending = 1'b0;
        fold_cr_seen = 1'b0;
        if (c == CL_LF) begin
          enter_phase(PH_BODY);
          done = 1'b1;
        end else begin
          emit_word(CHAR_SPACE);
        end
      end else if (c == CL_CR) begin
        fold_cr_seen = 1'b1;
        done = 1'b1;
      end else begin
        fold_pending = 1'b0;
        emit_word(CHAR_SPACE);
      end
    end else if (cr_seen) begin
      cr_seen = 1'b0;
      if (c == CL_LF) begin
        if (parse_phase == PH_VERSION) enter_phase(PH_HEADERS);
        else if (parse_phase == PH_HEADERS) fold_pending = 1'b1;
        done = 1'b1;
      end
    end
    if (!done) begin
      case (parse_phase)
        PH_IDLE: begin
          if (c == CL_LETTER) begin
            enter_phase(PH_METHOD);
            emit_word(b);
          end
        end
        PH_METHOD: begin
          if (c == CL_LETTER) emit_word(b);
          else if (c == CL_BLANK) enter_phase(PH_PATH);
        end
        PH_PATH: begin
          if (c == CL_LETTER || c == CL_SLASH) emit_word(b);
          else if (c == CL_BLANK) enter_phase(PH_VERSION);
        end
        PH_VERSION: begin
          if (c == CL_LETTER || c == CL_SLASH || c == CL_DIGIT || c == CL_DOT) emit_word(b);
          else if (c == CL_CR) cr_seen = 1'b1;
        end
        PH_HEADERS: begin
          if (c == CL_CR) cr_seen = 1'b1;
          else if (c != CL_LF) emit_word(b);
        end
        PH_BODY: begin
          if (c == CL_LETTER) emit_word(b);
        end
        default: ;
      endcase
    end
    foreach (step_words[i]) begin
      w = step_words[i];
      w.last = (i == step_words.size() - 1);
      field_words_due.push_back(w);
    end
    if (last) reset_parser();
  endtask

  // ---------------------------------------------------------------- stimulus
  task automatic queue_byte(input logic [7:0] b, input logic last);
    req_item_t it;
    it.data = b;
    it.last = last;
    it.tx_idle = cur_tx_idle;
    it.rx_idle = cur_rx_idle;
    it.drain = next_drain;
    it.stall = next_stall;
    next_drain = 1'b0;
    next_stall = 1'b0;
    request_words.push_back(it);
    queued_count++;
  endtask

  task automatic queue_text(input string s);
    for (int i = 0; i < s.len(); i++) queue_byte(s[i], 1'b0);
  endtask

  function automatic logic [7:0] rand_letter();
    return $urandom_range(1) ? 8'($urandom_range(65, 90)) : 8'($urandom_range(97, 122));
  endfunction

  task automatic build_request(input bit huge);
    int    n;
    int    lines;
    int    r;
    string ver;
    ver = "HTTP/1.";
    req_bytes.delete();
    n = huge ? 270 : $urandom_range(1, 6);
    repeat (n) req_bytes.push_back(rand_letter());
    req_bytes.push_back($urandom_range(1) ? CHAR_SPACE : CHAR_TAB);
    req_bytes.push_back(CHAR_SLASH);
    n = huge ? 270 : $urandom_range(0, 12);
    repeat (n) begin
      r = $urandom_range(9);
      if (r < 5) req_bytes.push_back(rand_letter());
      else if (r < 8) req_bytes.push_back(CHAR_SLASH);
      else req_bytes.push_back(8'($urandom_range(255)));
    end
    req_bytes.push_back($urandom_range(1) ? CHAR_SPACE : CHAR_TAB);
    for (int i = 0; i < ver.len(); i++) req_bytes.push_back(8'(ver[i]));
    req_bytes.push_back(8'($urandom_range(48, 57)));
    if ($urandom_range(9) == 0) begin
      req_bytes.push_back(CHAR_CR);
      req_bytes.push_back(8'($urandom_range(255)));
    end
    req_bytes.push_back(CHAR_CR);
    req_bytes.push_back(CHAR_LF);
    lines = huge ? 1 : $urandom_range(0, 4);
    repeat (lines) begin
      n = $urandom_range(1, 8);
      repeat (n) req_bytes.push_back(rand_letter());
      req_bytes.push_back(CHAR_COLON);
      req_bytes.push_back(CHAR_SPACE);
      n = huge ? 300 : $urandom_range(0, 16);
      repeat (n) begin
        r = $urandom_range(19);
        if (r == 0) begin
          req_bytes.push_back(CHAR_CR);
          req_bytes.push_back(8'($urandom_range(255)));
        end else if (r == 1) begin
          req_bytes.push_back(CHAR_LF);
        end else if (r == 2) begin
          req_bytes.push_back(CHAR_TAB);
        end else begin
          req_bytes.push_back(8'($urandom_range(32, 255)));
        end
      end
      req_bytes.push_back(CHAR_CR);
      req_bytes.push_back(CHAR_LF);
      if ($urandom_range(9) == 0) begin
        req_bytes.push_back(CHAR_CR);
        req_bytes.push_back(8'($urandom_range(255)));
      end
    end
    req_bytes.push_back(CHAR_CR);
    req_bytes.push_back(CHAR_LF);
    n = huge ? 270 : $urandom_range(0, 20);
    repeat (n) req_bytes.push_back($urandom_range(4) ? rand_letter() : 8'($urandom_range(255)));
  endtask

  task automatic queue_request(input bit huge);
    int stop;
    build_request(huge);
    stop = req_bytes.size();
    if (!huge && $urandom_range(99) < 15) stop = $urandom_range(1, req_bytes.size());
    for (int i = 0; i < stop; i++) queue_byte(req_bytes[i], i == stop - 1);
  endtask

  task automatic queue_noise();
    int n;
    n = $urandom_range(1, 15);
    repeat (n) queue_byte(8'($urandom_range(255)), $urandom_range(19) == 0);
  endtask

  // ---------------------------------------------------------------- driver
  always @(posedge clk) begin : drive
    req_item_t it;
    logic      launch;
    if (rst) begin
      in_valid <= 1'b0;
      byte_value <= 8'd0;
      last_byte <= 1'b0;
    end else begin
      if (in_valid && in_ready) predict_fields(byte_value, last_byte);
      if (!in_valid || in_ready) begin
        launch = 1'b0;
        if (request_words.size() > 0) begin
          it = request_words[0];
          if ((!it.drain || field_words_due.size() == 0) &&
              $urandom_range(99) >= it.tx_idle) begin
            void'(request_words.pop_front());
            launch = 1'b1;
            rx_idle_pct = it.rx_idle;
            if (it.stall) stall_requests++;
          end
        end
        in_valid <= launch;
        if (launch) begin
          byte_value <= it.data;
          last_byte <= it.last;
        end
      end
    end
  end

  // ---------------------------------------------------------------- monitor
  task automatic compare_field(input string name, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      failures++;
    end
  endtask

  always @(posedge clk) begin : watch
    field_word_t w;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (field_words_due.size() == 0) begin
          $error("unexpected word: kind %0d byte %0d position %0d",
                 field_kind, out_byte, field_position);
          failures++;
        end else begin
          w = field_words_due.pop_front();
          compare_field("field_kind", w.kind, field_kind);
          compare_field("out_byte", w.data, out_byte);
          compare_field("field_position", w.pos, field_position);
          compare_field("overflow", w.ovf, overflow);
          compare_field("run_last", w.last, run_last);
        end
      end
      if (stall_served != stall_requests) begin
        stall_served++;
        stall_left = LONG_HOLD;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // ---------------------------------------------------------------- sequence
  initial begin : run
    int target;
    bit stall_queued;
    // opening request: every field, dropped CR, folded breaks, body entry
    queue_text("Az\t/1 9.");
    queue_byte(CHAR_CR, 1'b0);
    queue_text("x");
    queue_byte(CHAR_CR, 1'b0);
    queue_byte(CHAR_LF, 1'b0);
    queue_byte(CHAR_COLON, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(CHAR_CR, 1'b0);
    queue_byte(CHAR_LF, 1'b0);
    queue_byte(CHAR_CR, 1'b0);
    queue_text("q");
    queue_byte(CHAR_CR, 1'b0);
    queue_byte(CHAR_LF, 1'b0);
    queue_byte(CHAR_CR, 1'b0);
    queue_byte(CHAR_LF, 1'b0);
    queue_text("Z");
    queue_byte(8'h00, 1'b0);
    queue_byte("K", 1'b1);

    queued_count = 0;
    stall_queued = 1'b0;
    for (int stage = 0; stage < 3; stage++) begin
      cur_tx_idle = (stage == 0) ? 26 : (stage == 1) ? 69 : 0;
      cur_rx_idle = (stage == 0) ? 69 : (stage == 1) ? 26 : 0;
      target = (stage + 1) * 633;
      if (stage == 1) next_drain = 1'b1;
      if (stage == 0) queue_request(1'b1);
      while (queued_count < target) begin
        if (stage == 2 && !stall_queued && queued_count > target - 300) begin
          next_stall = 1'b1;
          stall_queued = 1'b1;
        end
        if ($urandom_range(99) < 80) queue_request(1'b0);
        else queue_noise();
      end
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    wait (request_words.size() == 0);
    @(posedge clk);
    while (in_valid || field_words_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (failures == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
